>>> rtl/eep_pkg.sv
// Shared constants, register indexes and the control/status structs of the
// EMG envelope detector. Used by eep_engine and emg_envelope_percent.
package eep_pkg;

  // Fixed-point formats: sample magnitude, envelope fraction, EMA coefficient.
  localparam int SAMPLE_BITS = 12;
  localparam int FRAC_BITS   = 16;
  localparam int ALPHA_W     = 16;
  localparam int ENV_W       = SAMPLE_BITS + FRAC_BITS;

  // Accumulator holds env << ALPHA_W plus a signed alpha*(x_fx - env) term.
  localparam int ACC_W       = ENV_W + ALPHA_W + 2;

  // Percent output: quotient bits and the scale factor of full range.
  localparam int PCT_W       = 7;
  localparam int PCT_SCALE   = 100;
  localparam int REM_W       = ENV_W + PCT_W;

  // Block length register and the sample counter that can hold 256.
  localparam int BLK_W       = 8;
  localparam int CNT_W       = BLK_W + 1;

  // Step counter of the sequencer, sized for the longer of the two loops.
  localparam int STEP_W      = $clog2(ALPHA_W);

  // Configuration bus.
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 4;

  // Register reset values.
  localparam logic [SAMPLE_BITS-1:0] DC_OFFSET_RST = SAMPLE_BITS'(1280);
  localparam logic [ALPHA_W-1:0]     ALPHA_RST     = ALPHA_W'(1966);
  localparam logic [SAMPLE_BITS-1:0] CEILING_RST   = SAMPLE_BITS'(220);
  localparam logic [BLK_W-1:0]       BLOCK_LEN_RST = BLK_W'(10);

  // Register indexes (byte address bits [3:2]).
  typedef enum logic [1:0] {
    REG_DC_OFFSET = 2'd0,
    REG_ALPHA     = 2'd1,
    REG_CEILING   = 2'd2,
    REG_BLOCK_LEN = 2'd3
  } reg_idx_t;

  // Command from the top level to the engine.
  typedef struct packed {
    logic                   start;
    logic                   block_end;
    logic                   ack;
    logic [SAMPLE_BITS-1:0] x;
    logic [ALPHA_W-1:0]     alpha;
    logic [SAMPLE_BITS-1:0] ceiling;
  } eep_cmd_t;

  // Status from the engine back to the top level.
  typedef struct packed {
    logic                   idle;
    logic                   done;
    logic [PCT_W-1:0]       percent;
    logic [SAMPLE_BITS-1:0] level;
  } eep_sts_t;

endpackage

>>> rtl/emg_envelope_percent.sv
// Top level of the EMG envelope detector: configuration registers, block
// counter, input/output handshakes and the result register.
// Depends on eep_pkg and eep_engine.
//
//   Channel  Direction  Handshake               Payload
//   in_      input      in_valid / in_stall     in_sample
//   out_     output     out_valid / out_stall   out_percent, out_envelope_level
//   APB      config     psel, penable, pwrite   paddr, pwdata, prdata, pready
//
// A sample runs 16 shift-add steps of the EMA multiply on the shared adder,
// then an update step, and the engine returns to idle. A sample that ends a
// block goes on with a scaling step, 7 restoring divide steps on that adder
// and a done state that hands the result to the output register, waiting
// there while that register is full and stalled.
// Reset (rst_n low, synchronous) loads the register defaults, clears the
// envelope and the block count. in_stall is high while the engine works or
// while a finished result waits for the output register to free up.
module emg_envelope_percent (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [eep_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [eep_pkg::PCT_W-1:0]       out_percent,
  output logic [eep_pkg::SAMPLE_BITS-1:0] out_envelope_level,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [eep_pkg::ADDR_W-1:0]      paddr,
  input  logic [eep_pkg::DATA_W-1:0]      pwdata,
  output logic [eep_pkg::DATA_W-1:0]      prdata,
  output logic                            pready
);

  logic [eep_pkg::SAMPLE_BITS-1:0] dc_offset_r;
  logic [eep_pkg::ALPHA_W-1:0]     alpha_r;
  logic [eep_pkg::SAMPLE_BITS-1:0] ceiling_r;
  logic [eep_pkg::BLK_W-1:0]       block_len_r;
  logic [eep_pkg::BLK_W-1:0]       count_r, count_nxt;

  logic                            out_valid_r;
  logic [eep_pkg::PCT_W-1:0]       out_percent_r;
  logic [eep_pkg::SAMPLE_BITS-1:0] out_level_r;

  eep_pkg::reg_idx_t               reg_idx;
  logic                            cfg_wr;
  logic                            in_xfer, out_free;
  logic [eep_pkg::SAMPLE_BITS-1:0] rect;
  logic [eep_pkg::CNT_W-1:0]       blk_len, count_inc;
  logic                            block_end;

  eep_pkg::eep_cmd_t cmd;
  eep_pkg::eep_sts_t sts;

  // Configuration port: always ready, write on the access cycle.
  assign pready  = 1'b1;
  assign reg_idx = eep_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_offset_r <= eep_pkg::DC_OFFSET_RST;
      alpha_r     <= eep_pkg::ALPHA_RST;
      ceiling_r   <= eep_pkg::CEILING_RST;
      block_len_r <= eep_pkg::BLOCK_LEN_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        eep_pkg::REG_DC_OFFSET: dc_offset_r <= pwdata[eep_pkg::SAMPLE_BITS-1:0];
        eep_pkg::REG_ALPHA:     alpha_r     <= pwdata[eep_pkg::ALPHA_W-1:0];
        eep_pkg::REG_CEILING:   ceiling_r   <= pwdata[eep_pkg::SAMPLE_BITS-1:0];
        eep_pkg::REG_BLOCK_LEN: block_len_r <= pwdata[eep_pkg::BLK_W-1:0];
        default: begin
          dc_offset_r <= dc_offset_r;
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      eep_pkg::REG_DC_OFFSET: prdata = eep_pkg::DATA_W'(dc_offset_r);
      eep_pkg::REG_ALPHA:     prdata = eep_pkg::DATA_W'(alpha_r);
      eep_pkg::REG_CEILING:   prdata = eep_pkg::DATA_W'(ceiling_r);
      eep_pkg::REG_BLOCK_LEN: prdata = eep_pkg::DATA_W'(block_len_r);
      default:                prdata = '0;
    endcase
  end

  // Input transfer, rectification and block counting.
  assign in_stall  = !sts.idle;
  assign in_xfer   = in_valid && !in_stall;
  assign rect      = (in_sample >= dc_offset_r) ? (in_sample - dc_offset_r)
                                                : (dc_offset_r - in_sample);
  // A zero block length counts as 256 samples.
  assign blk_len   = (block_len_r == '0) ? {1'b1, {eep_pkg::BLK_W{1'b0}}}
                                         : {1'b0, block_len_r};
  assign count_inc = {1'b0, count_r} + 1'b1;
  assign block_end = (count_inc >= blk_len);
  assign count_nxt = block_end ? '0 : count_inc[eep_pkg::BLK_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (in_xfer) begin
      count_r <= count_nxt;
    end
  end

  // The result register frees up when empty or when its transfer completes.
  assign out_free = !out_valid_r || !out_stall;

  assign cmd.start     = in_xfer;
  assign cmd.block_end = block_end;
  assign cmd.ack       = out_free;
  assign cmd.x         = rect;
  assign cmd.alpha     = alpha_r;
  assign cmd.ceiling   = ceiling_r;

  eep_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .sts   (sts)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= sts.done;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && sts.done) begin
      out_percent_r <= sts.percent;
      out_level_r   <= sts.level;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_percent        = out_percent_r;
  assign out_envelope_level = out_level_r;

endmodule

>>> rtl/eep_engine.sv
// Iterative arithmetic engine: holds the envelope, runs the EMA update as a
// shift-add multiply and the percent as a restoring divide on one adder.
// Depends on eep_pkg.
module eep_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  eep_pkg::eep_cmd_t cmd,
  output eep_pkg::eep_sts_t sts
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_UPD   = 6'b000100,
    S_SCALE = 6'b001000,
    S_DIV   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [eep_pkg::ENV_W-1:0]         env_r, env_nxt;
  logic [eep_pkg::ACC_W-1:0]         acc_r, acc_nxt;
  logic [eep_pkg::ACC_W-1:0]         mcand_r, mcand_nxt;
  logic [eep_pkg::ALPHA_W-1:0]       mplier_r, mplier_nxt;
  logic [eep_pkg::STEP_W-1:0]        step_r, step_nxt;
  logic                              blk_end_r, blk_end_nxt;
  logic [eep_pkg::SAMPLE_BITS-1:0]   ceil_r, ceil_nxt;
  logic [eep_pkg::REM_W-1:0]         dvs_r, dvs_nxt;
  logic [eep_pkg::PCT_W-1:0]         q_r, q_nxt;

  // Shared adder/subtractor.
  logic [eep_pkg::ACC_W-1:0] alu_a, alu_b, alu_sum;
  logic                      alu_sub;

  logic [eep_pkg::ENV_W-1:0] x_fx, ceil_fx, env_upd;

  assign x_fx    = {cmd.x, {eep_pkg::FRAC_BITS{1'b0}}};
  assign ceil_fx = {ceil_r, {eep_pkg::FRAC_BITS{1'b0}}};
  assign env_upd = acc_r[eep_pkg::ALPHA_W +: eep_pkg::ENV_W];

  // Operand selection for the shared adder of the multiply and divide steps.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_r)
      S_MUL: begin
        alu_a = acc_r;
        alu_b = mplier_r[0] ? mcand_r : '0;
      end
      S_DIV: begin
        alu_a   = acc_r;
        alu_b   = {{(eep_pkg::ACC_W - eep_pkg::REM_W){1'b0}}, dvs_r};
        alu_sub = 1'b1;
      end
      default: begin
        alu_a = '0;
      end
    endcase
    alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b)
              + {{(eep_pkg::ACC_W-1){1'b0}}, alu_sub};
  end

  // Sequencer.
  always_comb begin
    state_nxt   = state_r;
    env_nxt     = env_r;
    acc_nxt     = acc_r;
    mcand_nxt   = mcand_r;
    mplier_nxt  = mplier_r;
    step_nxt    = step_r;
    blk_end_nxt = blk_end_r;
    ceil_nxt    = ceil_r;
    dvs_nxt     = dvs_r;
    q_nxt       = q_r;
    case (state_r)
      S_IDLE: begin
        // Start: acc = env << ALPHA_W, multiplicand = x_fx - env (signed).
        if (cmd.start) begin
          acc_nxt     = {{(eep_pkg::ACC_W - eep_pkg::ENV_W - eep_pkg::ALPHA_W){1'b0}},
                         env_r, {eep_pkg::ALPHA_W{1'b0}}};
          mcand_nxt   = {{(eep_pkg::ACC_W - eep_pkg::ENV_W){1'b0}}, x_fx}
                        - {{(eep_pkg::ACC_W - eep_pkg::ENV_W){1'b0}}, env_r};
          mplier_nxt  = cmd.alpha;
          step_nxt    = '0;
          blk_end_nxt = cmd.block_end;
          ceil_nxt    = cmd.ceiling;
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        // One coefficient bit per cycle, LSB first.
        acc_nxt    = alu_sum;
        mcand_nxt  = {mcand_r[eep_pkg::ACC_W-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[eep_pkg::ALPHA_W-1:1]};
        step_nxt   = step_r + 1'b1;
        if (step_r == eep_pkg::STEP_W'(eep_pkg::ALPHA_W - 1)) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        // Drop the coefficient fraction; clamp to the ceiling at block end.
        if (blk_end_r) begin
          env_nxt   = (env_upd > ceil_fx) ? ceil_fx : env_upd;
          state_nxt = S_SCALE;
        end else begin
          env_nxt   = env_upd;
          state_nxt = S_IDLE;
        end
      end
      S_SCALE: begin
        // Dividend env*100, divisor ceiling aligned to the top quotient bit.
        acc_nxt   = {{(eep_pkg::ACC_W - eep_pkg::ENV_W){1'b0}}, env_r}
                    * eep_pkg::ACC_W'(eep_pkg::PCT_SCALE);
        dvs_nxt   = {1'b0, ceil_fx, {(eep_pkg::PCT_W-1){1'b0}}};
        q_nxt     = '0;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // Restoring divide: keep the difference when it is not negative.
        if (!alu_sum[eep_pkg::ACC_W-1]) begin
          acc_nxt = alu_sum;
          q_nxt   = {q_r[eep_pkg::PCT_W-2:0], 1'b1};
        end else begin
          q_nxt   = {q_r[eep_pkg::PCT_W-2:0], 1'b0};
        end
        dvs_nxt  = {1'b0, dvs_r[eep_pkg::REM_W-1:1]};
        step_nxt = step_r + 1'b1;
        if (step_r == eep_pkg::STEP_W'(eep_pkg::PCT_W - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (cmd.ack) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state and the envelope reset; working registers need none.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      env_r   <= '0;
    end else begin
      state_r <= state_nxt;
      env_r   <= env_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r     <= acc_nxt;
    mcand_r   <= mcand_nxt;
    mplier_r  <= mplier_nxt;
    step_r    <= step_nxt;
    blk_end_r <= blk_end_nxt;
    ceil_r    <= ceil_nxt;
    dvs_r     <= dvs_nxt;
    q_r       <= q_nxt;
  end

  // Status. A zero ceiling reports zero percent.
  assign sts.idle    = (state_r == S_IDLE);
  assign sts.done    = (state_r == S_DONE);
  assign sts.percent = (ceil_r == '0) ? '0 : q_r;
  assign sts.level   = env_r[eep_pkg::FRAC_BITS +: eep_pkg::SAMPLE_BITS];

endmodule

>>> bench/emg_envelope_percent_tb.sv
// Self-checking testbench for emg_envelope_percent: random samples, register phases and
// an envelope/percent predictor checked against every output transfer.
// Depends on eep_pkg and the emg_envelope_percent RTL.
`timescale 1ns / 100ps

module emg_envelope_percent_tb;

  // Expected contents of one output transfer.
  typedef struct {
    logic [eep_pkg::PCT_W-1:0]       percent;
    logic [eep_pkg::SAMPLE_BITS-1:0] level;
  } level_t;

  localparam int SETTLE_CYCLES = 40;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [eep_pkg::SAMPLE_BITS-1:0] in_sample = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [eep_pkg::PCT_W-1:0]       out_percent;
  logic [eep_pkg::SAMPLE_BITS-1:0] out_envelope_level;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [eep_pkg::ADDR_W-1:0]      paddr = '0;
  logic [eep_pkg::DATA_W-1:0]      pwdata = '0;
  logic [eep_pkg::DATA_W-1:0]      prdata;
  logic                            pready;

  // Samples waiting to be sent and results waiting to arrive.
  logic [eep_pkg::SAMPLE_BITS-1:0] raw_samples[$];
  level_t                          due_levels[$];
  level_t                          got_due;

  // Predictor copy of the registers and the detector state.
  logic [eep_pkg::SAMPLE_BITS-1:0] cur_offset;
  logic [eep_pkg::ALPHA_W-1:0]     cur_alpha;
  logic [eep_pkg::SAMPLE_BITS-1:0] cur_ceiling;
  logic [eep_pkg::BLK_W-1:0]       cur_block_len;
  logic [eep_pkg::ENV_W-1:0]       env_fx;
  logic [eep_pkg::CNT_W-1:0]       blk_count;

  int  mismatches = 0;
  int  fed = 0;
  bit  pace_gaps = 1'b1;

  emg_envelope_percent uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_percent        (out_percent),
    .out_envelope_level (out_envelope_level),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Apply one sample to the envelope and queue the block result when it ends a block.
  task automatic track_envelope(input logic [eep_pkg::SAMPLE_BITS-1:0] s);
    logic [eep_pkg::SAMPLE_BITS-1:0] x;
    logic [63:0]                     mix;
    logic [eep_pkg::CNT_W-1:0]       span;
    logic [eep_pkg::CNT_W-1:0]       next_cnt;
    logic [eep_pkg::ENV_W-1:0]       ceil_fx;
    level_t                          res;
    x = (s >= cur_offset) ? s - cur_offset : cur_offset - s;
    mix = 64'(cur_alpha) * 64'({x, 16'h0000}) + (64'd65536 - 64'(cur_alpha)) * 64'(env_fx);
    env_fx = eep_pkg::ENV_W'(mix >> eep_pkg::FRAC_BITS);
    span = (cur_block_len == '0) ? eep_pkg::CNT_W'(256)
                                 : eep_pkg::CNT_W'(cur_block_len);
    next_cnt = blk_count + 1'b1;
    if (next_cnt < span) begin
      blk_count = next_cnt;
    end else begin
      blk_count = '0;
      ceil_fx = {cur_ceiling, 16'h0000};
      if (env_fx > ceil_fx) begin
        env_fx = ceil_fx;
      end
      res.percent = (ceil_fx == '0) ? '0 :
                    eep_pkg::PCT_W'((64'(env_fx) * 64'(eep_pkg::PCT_SCALE)) / 64'(ceil_fx));
      res.level = env_fx[eep_pkg::ENV_W-1:eep_pkg::FRAC_BITS];
      due_levels.push_back(res);
    end
  endtask

  // Sender: a held transfer keeps its payload; otherwise take the next sample or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        track_envelope(in_sample);
      end
      if (raw_samples.size() > 0 && !(pace_gaps && $urandom_range(99) < 31)) begin
        in_valid <= 1'b1;
        in_sample <= raw_samples.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: check each output transfer against the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_levels.size() == 0) begin
          report_mismatch($sformatf("unexpected result percent=%0d level=%0d",
                                    out_percent, out_envelope_level));
        end else begin
          got_due = due_levels.pop_front();
          if (out_percent !== got_due.percent) begin
            report_mismatch($sformatf("percent %0d, expected %0d",
                                      out_percent, got_due.percent));
          end
          if (out_envelope_level !== got_due.level) begin
            report_mismatch($sformatf("envelope_level %0d, expected %0d",
                                      out_envelope_level, got_due.level));
          end
        end
      end
      out_stall <= pace_gaps && ($urandom_range(99) < 31);
    end
  end

  // Register write: setup cycle, then access cycle until pready.
  task automatic reg_write(input eep_pkg::reg_idx_t idx,
                           input logic [eep_pkg::DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      eep_pkg::REG_DC_OFFSET: cur_offset = value[eep_pkg::SAMPLE_BITS-1:0];
      eep_pkg::REG_ALPHA:     cur_alpha = value[eep_pkg::ALPHA_W-1:0];
      eep_pkg::REG_CEILING:   cur_ceiling = value[eep_pkg::SAMPLE_BITS-1:0];
      eep_pkg::REG_BLOCK_LEN: cur_block_len = value[eep_pkg::BLK_W-1:0];
      default: ;
    endcase
  endtask

  // Same write with random junk in the bits above the register.
  task automatic reg_write_junk(input eep_pkg::reg_idx_t idx, input int unsigned bits,
                                input logic [eep_pkg::DATA_W-1:0] value);
    logic [eep_pkg::DATA_W-1:0] mask;
    mask = (eep_pkg::DATA_W'(1) << bits) - 1'b1;
    reg_write(idx, (value & mask) | ($urandom() & ~mask));
  endtask

  // Wait until every sample is taken and every result has come (or the guard runs out), then let the engine finish.
  task automatic settle();
    int guard;
    guard = 0;
    while ((raw_samples.size() > 0 || in_valid || due_levels.size() > 0) && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [eep_pkg::SAMPLE_BITS-1:0] near_offset();
    int v;
    v = int'(cur_offset) + int'($urandom_range(600)) - 300;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return eep_pkg::SAMPLE_BITS'(v);
  endfunction

  task automatic push_sample(input logic [eep_pkg::SAMPLE_BITS-1:0] s);
    raw_samples.push_back(s);
    fed++;
  endtask

  // Main sequence: reset, directed cases, then random register phases.
  initial begin
    int n;
    int ph;
    cur_offset = eep_pkg::DC_OFFSET_RST;
    cur_alpha = eep_pkg::ALPHA_RST;
    cur_ceiling = eep_pkg::CEILING_RST;
    cur_block_len = eep_pkg::BLOCK_LEN_RST;
    env_fx = '0;
    blk_count = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: extremes and values around the default baseline.
    push_sample(12'd0);    push_sample(12'd4095); push_sample(12'd1280);
    push_sample(12'd1279); push_sample(12'd1281); push_sample(12'd2048);
    push_sample(12'd4095); push_sample(12'd4095); push_sample(12'd0);
    push_sample(12'd2560);
    settle();

    // Nearly full alpha, no baseline, full ceiling, a result per sample.
    reg_write(eep_pkg::REG_DC_OFFSET, 32'd0);
    reg_write(eep_pkg::REG_ALPHA, 32'd65535);
    reg_write(eep_pkg::REG_CEILING, 32'd4095);
    reg_write(eep_pkg::REG_BLOCK_LEN, 32'd1);
    push_sample(12'd4095); push_sample(12'd0); push_sample(12'd4095); push_sample(12'd2730);
    settle();

    // Zero alpha holds the envelope; block length lowered below the count.
    reg_write(eep_pkg::REG_ALPHA, 32'd0);
    reg_write(eep_pkg::REG_BLOCK_LEN, 32'd3);
    push_sample(12'd4095); push_sample(12'd100);
    settle();
    reg_write(eep_pkg::REG_BLOCK_LEN, 32'd1);
    push_sample(12'd7);
    settle();

    // Zero ceiling clamps the envelope to zero and gives zero percent.
    reg_write(eep_pkg::REG_ALPHA, 32'd32768);
    reg_write(eep_pkg::REG_CEILING, 32'd0);
    push_sample(12'd4095); push_sample(12'd4095);
    settle();

    // Ceiling changed in the middle of a block, largest baseline.
    reg_write(eep_pkg::REG_CEILING, 32'd200);
    reg_write(eep_pkg::REG_BLOCK_LEN, 32'd4);
    reg_write(eep_pkg::REG_DC_OFFSET, 32'd4095);
    push_sample(12'd0); push_sample(12'd0);
    settle();
    reg_write(eep_pkg::REG_CEILING, 32'd100);
    push_sample(12'd4095); push_sample(12'd0);
    settle();

    // Random phases, each with fresh register values.
    ph = 0;
    while (fed < 1050) begin
      pace_gaps = (ph != 3);
      if ($urandom_range(1)) begin
        case ($urandom_range(3))
          0: reg_write_junk(eep_pkg::REG_DC_OFFSET, eep_pkg::SAMPLE_BITS, 32'd0);
          1: reg_write_junk(eep_pkg::REG_DC_OFFSET, eep_pkg::SAMPLE_BITS, 32'd4095);
          default: reg_write_junk(eep_pkg::REG_DC_OFFSET, eep_pkg::SAMPLE_BITS,
                                  $urandom_range(4095));
        endcase
      end
      if ($urandom_range(1)) begin
        case ($urandom_range(4))
          0: reg_write_junk(eep_pkg::REG_ALPHA, eep_pkg::ALPHA_W, 32'd0);
          1: reg_write_junk(eep_pkg::REG_ALPHA, eep_pkg::ALPHA_W, 32'd65535);
          2: reg_write_junk(eep_pkg::REG_ALPHA, eep_pkg::ALPHA_W, $urandom_range(1, 4000));
          default: reg_write_junk(eep_pkg::REG_ALPHA, eep_pkg::ALPHA_W,
                                  $urandom_range(65535));
        endcase
      end
      if ($urandom_range(1)) begin
        case ($urandom_range(9))
          0: reg_write_junk(eep_pkg::REG_CEILING, eep_pkg::SAMPLE_BITS, 32'd0);
          1: reg_write_junk(eep_pkg::REG_CEILING, eep_pkg::SAMPLE_BITS, 32'd1);
          2: reg_write_junk(eep_pkg::REG_CEILING, eep_pkg::SAMPLE_BITS, 32'd4095);
          3, 4: reg_write_junk(eep_pkg::REG_CEILING, eep_pkg::SAMPLE_BITS,
                               $urandom_range(4095));
          default: reg_write_junk(eep_pkg::REG_CEILING, eep_pkg::SAMPLE_BITS,
                                  $urandom_range(1, 300));
        endcase
      end
      // One long phase with a zero block length, otherwise mostly short blocks.
      n = $urandom_range(20, 120);
      if (ph == 1) begin
        reg_write_junk(eep_pkg::REG_BLOCK_LEN, eep_pkg::BLK_W, 32'd0);
        n = 300;
      end else if ($urandom_range(9) == 0) begin
        reg_write_junk(eep_pkg::REG_BLOCK_LEN, eep_pkg::BLK_W, 32'd255);
      end else if ($urandom_range(1)) begin
        reg_write_junk(eep_pkg::REG_BLOCK_LEN, eep_pkg::BLK_W, $urandom_range(1, 16));
      end else if (cur_block_len == '0 || cur_block_len > 16) begin
        reg_write_junk(eep_pkg::REG_BLOCK_LEN, eep_pkg::BLK_W, $urandom_range(1, 16));
      end
      repeat (n) begin
        if ($urandom_range(9) < 6) begin
          push_sample(near_offset());
        end else begin
          push_sample(eep_pkg::SAMPLE_BITS'($urandom_range(4095)));
        end
      end
      settle();
      ph++;
    end

    pace_gaps = 1'b1;
    settle();
    foreach (due_levels[i]) begin
      report_mismatch($sformatf("missing result percent=%0d level=%0d",
                                due_levels[i].percent, due_levels[i].level));
    end
    if (mismatches == 0) begin
      $display("** emg_envelope_percent: PASSED **");
    end else begin
      $display("** emg_envelope_percent: FAILED **");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #20_000_000;
    $display("** emg_envelope_percent: FAILED **");
    $finish;
  end

endmodule

>>> filelist.f
rtl/eep_pkg.sv
rtl/eep_engine.sv
rtl/emg_envelope_percent.sv
bench/emg_envelope_percent_tb.sv
